// ===== rtl/ptdq_pkg.sv =====
// Package for the periodic timer delta queue.
// Holds field widths, request and event codes, sequencer states and ALU ops.
// No dependencies.
`default_nettype none

package ptdq_pkg;

   localparam int NUM_TIMERS_DEF  = 16;
   localparam int DELAY_WIDTH_DEF = 32;

   localparam int KIND_W  = 2;
   localparam int FIELD_W = 32;
   localparam int ID_W    = 4;
   localparam int EV_W    = 3;
   localparam int STEP_W  = 16;

   localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd10;

   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

   localparam logic [EV_W-1:0] EV_REGISTERED = 3'd0;
   localparam logic [EV_W-1:0] EV_REMOVED    = 3'd1;
   localparam logic [EV_W-1:0] EV_FULL       = 3'd2;
   localparam logic [EV_W-1:0] EV_NOT_FOUND  = 3'd3;
   localparam logic [EV_W-1:0] EV_EXPIRED    = 3'd4;
   localparam logic [EV_W-1:0] EV_BAD_PERIOD = 3'd5;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } ptdq_alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EMIT,
      S_RG_SCAN,
      S_LI_START,
      S_LI_HEAD,
      S_LI_HEADB,
      S_LI_STEP,
      S_LI_CMP,
      S_LI_INSA,
      S_LI_INSB,
      S_UL_START,
      S_UL_WALK,
      S_UL_NEXT,
      S_UL_FIX,
      S_TK_SUB,
      S_TK_RD,
      S_TK_CHK
   } ptdq_state_type;

endpackage

`default_nettype wire

// ===== rtl/ptdq_if.sv =====
// Channel interfaces of the timer queue: request, response and CSR write.
// Depends on ptdq_pkg for the field widths.
`default_nettype none

interface ptdq_req_if import ptdq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [FIELD_W-1:0]  first_delay;
   logic [FIELD_W-1:0]  repeat_period;
   logic [ID_W-1:0]     target_id;

   modport source (output valid, kind, first_delay, repeat_period, target_id, input ready);
   modport sink   (input valid, kind, first_delay, repeat_period, target_id, output ready);
endinterface

interface ptdq_rsp_if import ptdq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [EV_W-1:0]  event_res;
   logic [ID_W-1:0]  slot_id;
   logic             last;

   modport source (output valid, event_res, slot_id, last, input ready);
   modport sink   (input valid, event_res, slot_id, last, output ready);
endinterface

interface ptdq_csr_if import ptdq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STEP_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/periodic_timer_delta_queue_core.sv =====
// Channel   | Dir | Payload                                     | Accepted when
// req_ch    | in  | kind, first_delay, repeat_period, target_id | valid && ready
// rsp_ch    | out | event_res, slot_id, last                    | valid && ready
// csr_ch    | in  | data (tick step)                            | valid && ready (always ready)
//
// One request at a time; the list walk reads one table entry at a time.
// Register: a scan for the lowest free slot, then a list walk to insert the new timer.
// Remove: walk to the slot and unlink. Tick: subtract the step at the head, re-insert expired timers.
// Synchronous active-high reset clears the list; slot tables need no clearing pass.
// A result waits in the output register; a stalled rsp_ch holds the sequencer before its next word.
// Depends on ptdq_pkg, ptdq_if and ptdq_alu.
`default_nettype none

module periodic_timer_delta_queue_core import ptdq_pkg::*; #(
   parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
   parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ptdq_req_if.sink        req_ch,
   ptdq_rsp_if.source      rsp_ch,
   ptdq_csr_if.sink        csr_ch
);

   localparam int DW = DELAY_WIDTH;
   localparam int IW = $clog2(NUM_TIMERS);
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int AW = ((DW > STEP_W) ? DW : STEP_W) + 1;
   localparam int SW = (IW > ID_W) ? IW : ID_W;

   // Slot tables.
   logic [DW-1:0] delta_mem  [NUM_TIMERS];
   logic [DW-1:0] period_mem [NUM_TIMERS];
   logic [IW-1:0] next_mem   [NUM_TIMERS];
   logic [DW-1:0] delta_q, period_q;
   logic [IW-1:0] next_q;

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          dw_en, nw_en, pw_en;
   logic [IW-1:0] dw_addr, nw_addr, pw_addr;
   logic [DW-1:0] dw_data, pw_data;
   logic [IW-1:0] nw_data;

   always_ff @(posedge clock) begin
      if (dw_en) begin
         delta_mem[dw_addr] <= dw_data;
      end
      if (nw_en) begin
         next_mem[nw_addr] <= nw_data;
      end
      if (pw_en) begin
         period_mem[pw_addr] <= pw_data;
      end
      if (rd_en) begin
         delta_q  <= delta_mem[rd_addr];
         period_q <= period_mem[rd_addr];
         next_q   <= next_mem[rd_addr];
      end
   end

   // Control and working registers.
   ptdq_state_type  state_ff, state_in;
   logic [KIND_W-1:0] op_ff, op_in;
   logic [IW-1:0]   s_ff, s_in, cur_ff, cur_in, nx_ff, nx_in;
   logic [IW-1:0]   head_ff, head_in;
   logic [SW-1:0]   pslot_ff, pslot_in, rslot_ff, rslot_in;
   logic [DW-1:0]   d_ff, d_in, p_ff, p_in, acc_ff, acc_in, tmp_ff, tmp_in;
   logic [AW-1:0]   sum_ff, sum_in;
   logic [CW-1:0]   k_ff, k_in, cnt_ff, cnt_in, limit_ff, limit_in, count_ff, count_in;
   logic            hd_ff, hd_in, pend_ff, pend_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [STEP_W-1:0] step_ff;
   logic [EV_W-1:0] res_ff, res_in;

   logic            ov_ff, olast_ff;
   logic [EV_W-1:0] oev_ff;
   logic [ID_W-1:0] oslot_ff;
   logic            out_load, out_last, out_free;
   logic [EV_W-1:0] out_ev;
   logic [SW-1:0]   out_slot;

   // Shared arithmetic unit.
   ptdq_alu_op_type alu_op;
   logic [AW-1:0]   alu_a, alu_b, alu_c, alu_r;
   logic            alu_borrow, alu_ge;

   ptdq_alu #(.AW(AW)) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .c      (alu_c),
      .r      (alu_r),
      .borrow (alu_borrow),
      .ge     (alu_ge)
   );

   // Input fields cut or widened to the delay width.
   logic [63:0] fd64, rp64;
   logic [31:0] tid32;
   logic [DW-1:0] req_d, req_p;
   logic [IW-1:0] req_id;
   logic          req_id_ok;

   assign fd64      = {32'b0, req_ch.first_delay};
   assign rp64      = {32'b0, req_ch.repeat_period};
   assign req_d     = fd64[DW-1:0];
   assign req_p     = rp64[DW-1:0];
   assign tid32     = {28'b0, req_ch.target_id};
   assign req_id    = tid32[IW-1:0];
   assign req_id_ok = (tid32 < NUM_TIMERS);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign out_free     = !ov_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      s_in     = s_ff;
      cur_in   = cur_ff;
      nx_in    = nx_ff;
      head_in  = head_ff;
      pslot_in = pslot_ff;
      rslot_in = rslot_ff;
      d_in     = d_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      sum_in   = sum_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      count_in = count_ff;
      hd_in    = hd_ff;
      pend_in  = pend_ff;
      valid_in = valid_ff;
      res_in   = res_ff;

      rd_en   = 1'b0;
      rd_addr = head_ff;
      dw_en   = 1'b0;
      dw_addr = s_ff;
      dw_data = d_ff;
      nw_en   = 1'b0;
      nw_addr = s_ff;
      nw_data = head_ff;
      pw_en   = 1'b0;
      pw_addr = s_ff;
      pw_data = p_ff;

      alu_op = ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      alu_c  = '0;

      out_load = 1'b0;
      out_ev   = res_ff;
      out_slot = rslot_ff;
      out_last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in = req_ch.kind;
               d_in  = req_d;
               p_in  = req_p;
               case (req_ch.kind)
                  KIND_REGISTER: begin
                     rslot_in = '0;
                     if (req_p == '0) begin
                        res_in   = EV_BAD_PERIOD;
                        state_in = S_EMIT;
                     end else if (count_ff >= CW'(NUM_TIMERS)) begin
                        res_in   = EV_FULL;
                        state_in = S_EMIT;
                     end else begin
                        cur_in   = '0;
                        state_in = S_RG_SCAN;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!req_id_ok || !valid_ff[req_id]) begin
                        res_in   = EV_NOT_FOUND;
                        rslot_in = tid32[SW-1:0];
                        state_in = S_EMIT;
                     end else begin
                        s_in     = req_id;
                        state_in = S_UL_START;
                     end
                  end
                  KIND_TICK: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        limit_in = count_ff;
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                        state_in = S_TK_SUB;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         // Lowest free slot, one candidate per cycle.
         S_RG_SCAN: begin
            if (!valid_ff[cur_ff]) begin
               s_in             = cur_ff;
               valid_in[cur_ff] = 1'b1;
               pw_en            = 1'b1;
               pw_addr          = cur_ff;
               state_in         = S_LI_START;
            end else begin
               cur_in = cur_ff + IW'(1);
            end
         end

         S_LI_START: begin
            if (count_ff == '0) begin
               head_in  = s_ff;
               dw_en    = 1'b1;
               count_in = count_ff + CW'(1);
               rslot_in = SW'(s_ff);
               res_in   = EV_REGISTERED;
               state_in = (op_ff == KIND_TICK) ? S_TK_RD : S_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = S_LI_HEAD;
            end
         end

         S_LI_HEAD: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(delta_q);
            alu_b  = AW'(d_ff);
            if (!alu_borrow) begin
               // New timer goes in front of the head.
               dw_en    = 1'b1;
               dw_addr  = head_ff;
               dw_data  = alu_r[DW-1:0];
               nw_en    = 1'b1;
               state_in = S_LI_HEADB;
            end else begin
               cur_in   = head_ff;
               acc_in   = delta_q;
               k_in     = CW'(1);
               state_in = S_LI_STEP;
            end
         end

         S_LI_HEADB: begin
            dw_en    = 1'b1;
            head_in  = s_ff;
            count_in = count_ff + CW'(1);
            rslot_in = SW'(s_ff);
            res_in   = EV_REGISTERED;
            state_in = (op_ff == KIND_TICK) ? S_TK_RD : S_EMIT;
         end

         S_LI_STEP: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(d_ff);
            alu_b  = AW'(acc_ff);
            if (k_ff < count_ff) begin
               nx_in    = next_q;
               rd_en    = 1'b1;
               rd_addr  = next_q;
               state_in = S_LI_CMP;
            end else begin
               // Append at the tail.
               nw_en    = 1'b1;
               nw_addr  = cur_ff;
               nw_data  = s_ff;
               dw_en    = 1'b1;
               dw_data  = alu_r[DW-1:0];
               count_in = count_ff + CW'(1);
               rslot_in = SW'(s_ff);
               res_in   = EV_REGISTERED;
               state_in = (op_ff == KIND_TICK) ? S_TK_RD : S_EMIT;
            end
         end

         S_LI_CMP: begin
            alu_op = ALU_ADD;
            alu_a  = AW'(acc_ff);
            alu_b  = AW'(delta_q);
            alu_c  = AW'(d_ff);
            if (alu_ge) begin
               sum_in   = alu_r;
               state_in = S_LI_INSA;
            end else begin
               acc_in   = alu_r[DW-1:0];
               cur_in   = nx_ff;
               k_in     = k_ff + CW'(1);
               state_in = S_LI_STEP;
            end
         end

         S_LI_INSA: begin
            alu_op   = ALU_SUB;
            alu_a    = AW'(d_ff);
            alu_b    = AW'(acc_ff);
            dw_en    = 1'b1;
            dw_data  = alu_r[DW-1:0];
            nw_en    = 1'b1;
            nw_data  = nx_ff;
            state_in = S_LI_INSB;
         end

         S_LI_INSB: begin
            alu_op   = ALU_SUB;
            alu_a    = sum_ff;
            alu_b    = AW'(d_ff);
            dw_en    = 1'b1;
            dw_addr  = nx_ff;
            dw_data  = alu_r[DW-1:0];
            nw_en    = 1'b1;
            nw_addr  = cur_ff;
            nw_data  = s_ff;
            count_in = count_ff + CW'(1);
            rslot_in = SW'(s_ff);
            res_in   = EV_REGISTERED;
            state_in = (op_ff == KIND_TICK) ? S_TK_RD : S_EMIT;
         end

         S_UL_START: begin
            if (head_ff == s_ff) begin
               hd_in = 1'b1;
               if (count_ff > CW'(1)) begin
                  rd_en    = 1'b1;
                  rd_addr  = s_ff;
                  state_in = S_UL_NEXT;
               end else begin
                  k_in     = CW'(1);
                  state_in = S_UL_FIX;
               end
            end else begin
               hd_in    = 1'b0;
               cur_in   = head_ff;
               k_in     = CW'(1);
               rd_en    = 1'b1;
               state_in = S_UL_WALK;
            end
         end

         S_UL_WALK: begin
            if (k_ff < count_ff && next_q == s_ff) begin
               if (k_ff < count_ff - CW'(1)) begin
                  rd_en    = 1'b1;
                  rd_addr  = s_ff;
                  state_in = S_UL_NEXT;
               end else begin
                  // Tail removal needs no delta fold.
                  hd_in    = 1'b0;
                  nx_in    = s_ff;
                  state_in = S_UL_FIX;
               end
            end else if (k_ff < count_ff) begin
               cur_in  = next_q;
               k_in    = k_ff + CW'(1);
               rd_en   = 1'b1;
               rd_addr = next_q;
            end else begin
               nx_in    = s_ff;
               state_in = S_UL_FIX;
            end
         end

         S_UL_NEXT: begin
            tmp_in   = delta_q;
            nx_in    = next_q;
            rd_en    = 1'b1;
            rd_addr  = next_q;
            // Marks that the successor fold is pending.
            k_in     = '0;
            state_in = S_UL_FIX;
         end

         S_UL_FIX: begin
            alu_op = ALU_ADD;
            alu_a  = AW'(delta_q);
            alu_b  = AW'(tmp_ff);
            // A fold is pending only when entered from the successor read.
            if (k_ff == '0) begin
               dw_en   = 1'b1;
               dw_addr = nx_ff;
               dw_data = alu_r[DW-1:0];
               if (hd_ff) begin
                  head_in = nx_ff;
               end else begin
                  nw_en   = 1'b1;
                  nw_addr = cur_ff;
                  nw_data = nx_ff;
               end
            end
            count_in = count_ff - CW'(1);
            if (op_ff == KIND_TICK) begin
               d_in     = p_ff;
               state_in = S_LI_START;
            end else begin
               valid_in[s_ff] = 1'b0;
               res_in         = EV_REMOVED;
               rslot_in       = SW'(s_ff);
               state_in       = S_EMIT;
            end
         end

         S_TK_SUB: begin
            alu_op   = ALU_SUB;
            alu_a    = AW'(delta_q);
            alu_b    = AW'(step_ff);
            dw_en    = 1'b1;
            dw_addr  = head_ff;
            dw_data  = alu_borrow ? '0 : alu_r[DW-1:0];
            state_in = S_TK_RD;
         end

         S_TK_RD: begin
            rd_en    = 1'b1;
            state_in = S_TK_CHK;
         end

         S_TK_CHK: begin
            out_ev   = EV_EXPIRED;
            out_slot = pslot_ff;
            if (count_ff != '0 && delta_q == '0 && cnt_ff < limit_ff) begin
               if (!pend_ff || out_free) begin
                  out_load = pend_ff;
                  out_last = 1'b0;
                  pend_in  = 1'b1;
                  pslot_in = SW'(head_ff);
                  s_in     = head_ff;
                  p_in     = period_q;
                  cnt_in   = cnt_ff + CW'(1);
                  state_in = S_UL_START;
               end
            end else if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         step_ff  <= TICK_STEP_RESET;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         if (csr_ch.valid) begin
            step_ff <= csr_ch.data;
         end
         if (out_load) begin
            ov_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   logic [31:0] out_slot32;
   assign out_slot32 = 32'(out_slot);

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      s_ff     <= s_in;
      cur_ff   <= cur_in;
      nx_ff    <= nx_in;
      pslot_ff <= pslot_in;
      rslot_ff <= rslot_in;
      d_ff     <= d_in;
      p_ff     <= p_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      sum_ff   <= sum_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      limit_ff <= limit_in;
      hd_ff    <= hd_in;
      res_ff   <= res_in;
      if (out_load) begin
         oev_ff   <= out_ev;
         oslot_ff <= out_slot32[ID_W-1:0];
         olast_ff <= out_last;
      end
   end

   assign rsp_ch.valid     = ov_ff;
   assign rsp_ch.event_res = oev_ff;
   assign rsp_ch.slot_id   = oslot_ff;
   assign rsp_ch.last      = olast_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_TIMERS))
      else $error("timer count exceeds table size");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == 32'(count_ff)))
      else $error("list length differs from slots in use");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!ov_ff || rsp_ch.ready))
      else $error("result word overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/ptdq_alu.sv =====
// Shared add/subtract unit with a compare against a third operand.
// Depends on ptdq_pkg for the operation type.
`default_nettype none

module ptdq_alu import ptdq_pkg::*; #(
   parameter int AW = DELAY_WIDTH_DEF + 1
) (
   input  ptdq_alu_op_type op,
   input  logic [AW-1:0]   a,
   input  logic [AW-1:0]   b,
   input  logic [AW-1:0]   c,
   output logic [AW-1:0]   r,
   output logic            borrow,
   output logic            ge
);

   logic [AW:0] full;

   always_comb begin
      if (op == ALU_SUB) begin
         full = {1'b0, a} - {1'b0, b};
      end else begin
         full = {1'b0, a} + {1'b0, b};
      end
   end

   assign r      = full[AW-1:0];
   assign borrow = (op == ALU_SUB) & full[AW];
   assign ge     = (full >= {1'b0, c});

endmodule

`default_nettype wire

// ===== verif/tb_periodic_timer_delta_queue_core.sv =====
// Testbench for the periodic timer delta queue core: register, remove and tick traffic
// checked word by word against a behavioral delta-list model held in the bench.
// Depends on ptdq_pkg, ptdq_if and the core RTL.
`timescale 1ns / 1ps

module tb_periodic_timer_delta_queue_core;
   import ptdq_pkg::*;

   localparam int NT = 16;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

   typedef struct packed {
      logic [EV_W-1:0] ev;
      logic [ID_W-1:0] slot;
      logic            last;
   } event_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptdq_req_if req_ch ();
   ptdq_rsp_if rsp_ch ();
   ptdq_csr_if csr_ch ();

   periodic_timer_delta_queue_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // Bench copy of the timer table.
   logic [31:0]     q_delta [NT];
   logic [31:0]     q_reload[NT];
   logic [ID_W-1:0] q_next  [NT];
   bit              q_used  [NT];
   logic [ID_W-1:0] q_head;
   int              q_count;
   logic [15:0]     q_step;

   event_word_type pending_events[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  rsp_random_stall = 1'b1;
   bit  req_random_gaps  = 1'b1;
   bit  hold_rsp = 1'b0;

   initial forever #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void list_insert(input logic [ID_W-1:0] s, input logic [31:0] d);
      logic [ID_W-1:0] cur, nx;
      logic [32:0] acc;
      bit placed;
      placed = 0;
      if (q_count == 0) begin
         q_head = s;
         q_delta[s] = d;
      end else if (q_delta[q_head] >= d) begin
         q_next[s] = q_head;
         q_delta[q_head] = q_delta[q_head] - d;
         q_delta[s] = d;
         q_head = s;
      end else begin
         cur = q_head;
         acc = q_delta[q_head];
         for (int k = 1; k < q_count; k++) begin
            nx = q_next[cur];
            if (acc + q_delta[nx] >= d) begin
               q_delta[s] = d - acc[31:0];
               q_next[s] = nx;
               q_delta[nx] = q_delta[nx] - q_delta[s];
               q_next[cur] = s;
               placed = 1;
               break;
            end
            acc = {1'b0, acc[31:0] + q_delta[nx]};
            cur = nx;
         end
         if (!placed) begin
            q_next[cur] = s;
            q_delta[s] = d - acc[31:0];
         end
      end
      q_count++;
   endfunction

   function automatic void list_unlink(input logic [ID_W-1:0] s);
      logic [ID_W-1:0] cur, nx, after;
      if (q_count == 0) return;
      if (q_head == s) begin
         if (q_count > 1) begin
            nx = q_next[s];
            q_delta[nx] = q_delta[nx] + q_delta[s];
            q_head = nx;
         end
      end else begin
         cur = q_head;
         for (int k = 1; k < q_count; k++) begin
            nx = q_next[cur];
            if (nx == s) begin
               if (k < q_count - 1) begin
                  after = q_next[s];
                  q_delta[after] = q_delta[after] + q_delta[s];
                  q_next[cur] = after;
               end
               break;
            end
            cur = nx;
         end
      end
      q_count--;
   endfunction

   function automatic void predict_events(input logic [KIND_W-1:0] kind,
         input logic [31:0] d, input logic [31:0] p, input logic [ID_W-1:0] id);
      int s, cnt, lim;
      if (kind == KIND_REGISTER) begin
         if (p == 0) begin
            pending_events.push_back('{EV_BAD_PERIOD, 4'd0, 1'b1});
            return;
         end
         if (q_count >= NT) begin
            pending_events.push_back('{EV_FULL, 4'd0, 1'b1});
            return;
         end
         for (s = 0; s < NT; s++) if (!q_used[s]) break;
         q_used[s] = 1;
         q_reload[s] = p;
         list_insert(s[ID_W-1:0], d);
         pending_events.push_back('{EV_REGISTERED, s[ID_W-1:0], 1'b1});
      end else if (kind == KIND_REMOVE) begin
         if (!q_used[id]) begin
            pending_events.push_back('{EV_NOT_FOUND, id, 1'b1});
            return;
         end
         list_unlink(id);
         q_used[id] = 0;
         pending_events.push_back('{EV_REMOVED, id, 1'b1});
      end else if (kind == KIND_TICK) begin
         if (q_count == 0) return;
         lim = q_count;
         cnt = 0;
         if (q_delta[q_head] > {16'd0, q_step}) q_delta[q_head] -= q_step;
         else q_delta[q_head] = 0;
         while (q_count > 0 && q_delta[q_head] == 0 && cnt < lim) begin
            s = q_head;
            list_unlink(s[ID_W-1:0]);
            list_insert(s[ID_W-1:0], q_reload[s]);
            pending_events.push_back('{EV_EXPIRED, s[ID_W-1:0], 1'b0});
            cnt++;
         end
         if (cnt > 0) pending_events[$].last = 1'b1;
      end
   endfunction

   // Valid stays up after an accept until the next word or a pause replaces it.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [31:0] d,
         input logic [31:0] p, input logic [ID_W-1:0] id);
      if (req_random_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.first_delay <= d;
      req_ch.repeat_period <= p;
      req_ch.target_id <= id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_events(kind, d, p, id);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_step(input logic [15:0] v);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      q_step = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Response side: random stall bursts, or a long hold when asked.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_ch.ready <= 1'b0;
         else if (rsp_random_stall && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_events.size() == 0)
            report_mismatch($sformatf("unexpected word ev=%0d slot=%0d",
                                      rsp_ch.event_res, rsp_ch.slot_id));
         else begin
            event_word_type e;
            e = pending_events.pop_front();
            if (rsp_ch.event_res !== e.ev)
               report_mismatch($sformatf("event_res %0d, want %0d", rsp_ch.event_res, e.ev));
            if (rsp_ch.slot_id !== e.slot)
               report_mismatch($sformatf("slot_id %0d, want %0d", rsp_ch.slot_id, e.slot));
            if (rsp_ch.last !== e.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_ch.last, e.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_periodic_timer_delta_queue_core NOT OK");
         $finish;
      end
   end

   function automatic logic [31:0] rand_delay();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 200);
      endcase
   endfunction

   task automatic test_directed();
      send_request(KIND_TICK, 0, 0, 0);                // empty tick
      send_request(KIND_REGISTER, 5, 0, 0);            // zero period
      send_request(KIND_REMOVE, 0, 0, 4'd15);          // unknown slot
      send_request(KIND_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF); // reserved kind
      send_request(KIND_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_request(KIND_REGISTER, 0, 32'd1, 0);
      send_request(KIND_REGISTER, 20, 32'd20, 0);
      send_request(KIND_REGISTER, 20, 32'd7, 0);       // ties go in front
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_REMOVE, 0, 0, 4'd0);           // remove tail
      send_request(KIND_REMOVE, 0, 0, 4'd2);
      for (int i = 0; i < 14; i++) send_request(KIND_REGISTER, 100 + i, 50, 0);
      send_request(KIND_REGISTER, 1, 1, 0);            // table full
      wait_drained();
   endtask

   task automatic test_step_settings();
      write_step(16'd0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_TICK, 0, 0, 0);
      write_step(16'hFFFF);
      repeat (4) send_request(KIND_TICK, 0, 0, 0);
      write_step(16'd1);
      repeat (3) send_request(KIND_TICK, 0, 0, 0);
      for (int i = 0; i < NT; i++) send_request(KIND_REMOVE, 0, 0, ID_W'(i));
      wait_drained();
   endtask

   task automatic test_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 8)
            send_request(KIND_REGISTER, rand_delay(),
                         ($urandom_range(0, 15) == 0) ? 32'd0 :
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 150),
                         ID_W'($urandom));
         else if (r < 12)
            send_request(KIND_REMOVE, $urandom, $urandom, ID_W'($urandom_range(0, 15)));
         else if (r < 19)
            send_request(KIND_TICK, $urandom, $urandom, ID_W'($urandom));
         else
            send_request(KIND_RESERVED, $urandom, $urandom, ID_W'($urandom));
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         repeat (6) send_request(KIND_REGISTER, $urandom_range(0, 50), 3, 0);
      join
      wait_drained();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.first_delay = '0;
      req_ch.repeat_period = '0;
      req_ch.target_id = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      for (int i = 0; i < NT; i++) begin
         q_used[i] = 0; q_delta[i] = 0; q_reload[i] = 0; q_next[i] = 0;
      end
      q_head = 0;
      q_count = 0;
      q_step = TICK_STEP_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_step_settings();
      test_backpressure();
      write_step(16'd5);
      test_random(200);
      write_step(16'd40);
      test_random(150);
      wait_drained();
      // Final stretch runs without idling on either side.
      req_random_gaps = 1'b0;
      rsp_random_stall = 1'b0;
      test_random(100);
      wait_drained();

      if (error_count == 0) $display("tb_periodic_timer_delta_queue_core OK");
      else $display("tb_periodic_timer_delta_queue_core NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ptdq_pkg.sv
rtl/ptdq_if.sv
rtl/ptdq_alu.sv
rtl/periodic_timer_delta_queue_core.sv
verif/tb_periodic_timer_delta_queue_core.sv
